@@ src/b64c_pkg.sv @@
// Shared types, constants and character mapping functions for the base64 codec.
`default_nettype none

package b64c_pkg;

   // Mode register values
   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   // Register indexes on the configuration port
   localparam int unsigned REG_MODE     = 0;
   localparam int unsigned CSR_ADDR_W   = 2;
   localparam int unsigned CSR_DATA_W   = 32;

   // Padding character '='
   localparam logic [7:0] PAD_CHAR = 8'h3D;

   // Job queue between front and back; depth must stay a power of two
   localparam int unsigned JOB_QUEUE_DEPTH = 2;
   localparam int unsigned JQ_PTR_W        = $clog2(JOB_QUEUE_DEPTH);
   localparam int unsigned JQ_CNT_W        = $clog2(JOB_QUEUE_DEPTH + 1);

   // One job: up to four result bytes, emitted in order bytes[0] .. bytes[last_idx]
   typedef struct packed {
      logic [1:0]      last_idx;
      logic [3:0][7:0] bytes;
      logic            none;
      logic            last;
      logic            early;
   } job_type;

   // Decoded alphabet symbol
   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } sym_type;

   // Map a 6-bit value to its alphabet character
   function automatic logic [7:0] enc_char(input logic [5:0] v);
      logic [7:0] wide;
      logic [7:0] ch;
      wide = {2'b00, v};
      case (v) inside
         [6'd0:6'd25]:  ch = wide + 8'h41;
         [6'd26:6'd51]: ch = wide + 8'h47;
         [6'd52:6'd61]: ch = wide - 8'd4;
         6'd62:         ch = 8'h2B;
         default:       ch = 8'h2F;
      endcase
      return ch;
   endfunction

   // Map a character to its 6-bit value, flag characters outside the alphabet
   function automatic sym_type dec_char(input logic [7:0] c);
      sym_type s;
      logic [7:0] diff;
      s.valid = 1'b1;
      diff    = 8'h00;
      case (c) inside
         [8'h41:8'h5A]: diff = c - 8'h41;
         [8'h61:8'h7A]: diff = c - 8'h47;
         [8'h30:8'h39]: diff = c + 8'd4;
         8'h2B:         diff = 8'd62;
         8'h2F:         diff = 8'd63;
         default:       s.valid = 1'b0;
      endcase
      s.value = diff[5:0];
      return s;
   endfunction

endpackage

`default_nettype wire

@@ src/b64c_front.sv @@
// Front end: accepts items, keeps the open group and builds result jobs.
`default_nettype none

module b64c_front
   import b64c_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       mode,
   input  wire logic       clear,
   input  wire logic       accept,
   input  wire logic [7:0] data_byte,
   input  wire logic       last_in,
   output job_type         job,
   output logic            job_valid
);

   logic [23:0] bits_ff, bits_in;
   logic [1:0]  count_ff, count_in;
   logic        halted_ff, halted_in;

   logic [23:0] enc_word;
   logic [23:0] enc_chunk;
   logic [23:0] dec_word;
   sym_type     sym;

   // Four characters of a chunk; keep selects how many of the last two are real
   function automatic logic [3:0][7:0] enc_quad(input logic [23:0] chunk,
                                                 input logic [1:0]  keep);
      logic [3:0][7:0] q;
      q[0] = enc_char(chunk[23:18]);
      q[1] = enc_char(chunk[17:12]);
      q[2] = (keep != 2'd0) ? enc_char(chunk[11:6]) : PAD_CHAR;
      q[3] = (keep == 2'd2) ? enc_char(chunk[5:0])  : PAD_CHAR;
      return q;
   endfunction

   assign enc_word  = {bits_ff[15:0], data_byte};
   assign enc_chunk = (count_ff == 2'd0) ? {data_byte, 16'h0000}
                                         : {bits_ff[7:0], data_byte, 8'h00};
   assign sym       = dec_char(data_byte);
   assign dec_word  = {bits_ff[17:0], sym.value};

   // Classify the item, update the group and build its job
   always_comb begin
      job       = '0;
      job_valid = 1'b0;
      bits_in   = bits_ff;
      count_in  = count_ff;
      halted_in = halted_ff;
      if (clear) begin
         bits_in   = '0;
         count_in  = '0;
         halted_in = 1'b0;
      end else if (accept) begin
         if (mode == MODE_ENCODE) begin
            if (count_ff == 2'd2) begin
               job.bytes    = enc_quad(enc_word, 2'd2);
               job.last_idx = 2'd3;
               job.last     = last_in;
               job_valid    = 1'b1;
               bits_in      = '0;
               count_in     = '0;
            end else if (last_in) begin
               job.bytes    = enc_quad(enc_chunk, count_ff);
               job.last_idx = 2'd3;
               job.last     = 1'b1;
               job_valid    = 1'b1;
               bits_in      = '0;
               count_in     = '0;
            end else begin
               bits_in  = enc_word;
               count_in = count_ff + 2'd1;
            end
         end else if (halted_ff) begin
            // Drop characters after a stop; close the stream on its last one
            if (last_in) begin
               job.none  = 1'b1;
               job.last  = 1'b1;
               job.early = 1'b1;
               job_valid = 1'b1;
               halted_in = 1'b0;
            end
         end else if (!sym.valid) begin
            // Stop: flush the partial group at once
            case (count_ff)
               2'd2: begin
                  job.bytes[0] = bits_ff[11:4];
                  job_valid    = 1'b1;
               end
               2'd3: begin
                  job.bytes[0] = bits_ff[17:10];
                  job.bytes[1] = bits_ff[9:2];
                  job.last_idx = 2'd1;
                  job_valid    = 1'b1;
               end
               default: begin
                  job_valid = 1'b0;
               end
            endcase
            bits_in   = '0;
            count_in  = '0;
            halted_in = 1'b1;
            if (last_in) begin
               job.none  = !job_valid;
               job.last  = 1'b1;
               job.early = 1'b1;
               job_valid = 1'b1;
               halted_in = 1'b0;
            end
         end else begin
            if (count_ff == 2'd3) begin
               job.bytes[0] = dec_word[23:16];
               job.bytes[1] = dec_word[15:8];
               job.bytes[2] = dec_word[7:0];
               job.last_idx = 2'd2;
               job_valid    = 1'b1;
               bits_in      = '0;
               count_in     = '0;
            end else begin
               bits_in  = dec_word;
               count_in = count_ff + 2'd1;
               // Truncated final group
               if (last_in) begin
                  case (count_ff)
                     2'd1: begin
                        job.bytes[0] = dec_word[11:4];
                     end
                     2'd2: begin
                        job.bytes[0] = dec_word[17:10];
                        job.bytes[1] = dec_word[9:2];
                        job.last_idx = 2'd1;
                     end
                     default: begin
                        job.none = 1'b1;
                     end
                  endcase
               end
            end
            if (last_in) begin
               job.last  = 1'b1;
               job_valid = 1'b1;
               bits_in   = '0;
               count_in  = '0;
            end
         end
      end
   end

   // Hold the open group
   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff   <= '0;
         count_ff  <= '0;
         halted_ff <= 1'b0;
      end else begin
         bits_ff   <= bits_in;
         count_ff  <= count_in;
         halted_ff <= halted_in;
      end
   end

endmodule

`default_nettype wire

@@ src/b64c_queue.sv @@
// Short job queue between the front end and the back end.
`default_nettype none

module b64c_queue
   import b64c_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    wr_en,
   input  wire job_type wr_job,
   input  wire logic    rd_en,
   output job_type      rd_job,
   output logic         full,
   output logic         empty
);

   job_type               entries_ff [JOB_QUEUE_DEPTH];
   logic [JQ_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [JQ_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [JQ_CNT_W-1:0]   count_ff, count_in;
   logic                  do_wr, do_rd;

   assign full   = (count_ff == JQ_CNT_W'(JOB_QUEUE_DEPTH));
   assign empty  = (count_ff == '0);
   assign do_wr  = wr_en && !full;
   assign do_rd  = rd_en && !empty;
   assign rd_job = entries_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + JQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + JQ_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + JQ_CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - JQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming job
   always_ff @(posedge clock) begin
      if (do_wr) begin
         entries_ff[wr_ptr_ff] <= wr_job;
      end
   end

endmodule

`default_nettype wire

@@ src/b64c_back.sv @@
// Back end: expands queued jobs into single results behind an output register.
`default_nettype none

module b64c_back
   import b64c_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire job_type head_job,
   input  wire logic    head_valid,
   output logic         head_done,
   input  wire logic    pop,
   output logic         empty,
   output logic [7:0]   out_byte,
   output logic         out_last,
   output logic         out_none,
   output logic         stopped_early
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic       load;
   logic       final_one;
   logic [7:0] byte_ff;
   logic       last_ff, none_ff, early_ff;

   assign load      = !valid_ff || pop;
   assign final_one = (idx_ff == head_job.last_idx);
   assign head_done = load && head_valid && final_one;

   // Step through the head job, one result per cycle while the output register is empty or popped
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            idx_in = final_one ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Load the output register
   always_ff @(posedge clock) begin
      if (load && head_valid) begin
         byte_ff  <= head_job.bytes[idx_ff];
         none_ff  <= head_job.none;
         last_ff  <= head_job.last && final_one;
         early_ff <= head_job.early && final_one;
      end
   end

   assign empty         = !valid_ff;
   assign out_byte      = byte_ff;
   assign out_last      = last_ff;
   assign out_none      = none_ff;
   assign stopped_early = early_ff;

endmodule

`default_nettype wire

@@ src/base64_codec.sv @@
// Top level of the streaming base64 codec: mode register, front end, job queue, back end.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-----------------------------------------
//  req      | in        | push / full          | req_data_byte, req_last_in
//  rsp      | out       | empty / pop          | rsp_out_byte, rsp_out_last, rsp_out_none,
//           |           |                      | rsp_stopped_early
//  csr      | in/out    | psel, penable, pready| paddr, pwrite, pwdata, prdata (mode at 0)
//
//  An item is taken while push is high and full is low; its job is registered in the queue,
//  and its results reach rsp through the back end's output register, one per cycle while
//  rsp is popped. Encoding gives 4 characters per 3 bytes; decoding is held to one
//  character per cycle by the input, giving 3 results per 4 characters.
//  The two-entry job queue lets the front end keep taking items while results wait.
//  Reset is synchronous and clears the mode, the open group, the queue and the output.
//  A write to mode clears the open group; write it only while the codec is idle.
`default_nettype none

module base64_codec
   import b64c_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  push,
   output logic                       full,
   input  wire logic [7:0]            req_data_byte,
   input  wire logic                  req_last_in,
   // response channel
   output logic                       empty,
   input  wire logic                  pop,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_out_last,
   output logic                       rsp_out_none,
   output logic                       rsp_stopped_early,
   // register port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   logic    mode_ff, mode_in;
   logic    mode_wr;
   logic    accept;
   job_type front_job;
   logic    front_valid;
   job_type head_job;
   logic    q_empty;
   logic    head_done;

   // Register port: single mode register
   assign pready  = 1'b1;
   assign mode_wr = psel && penable && pwrite && pready
                    && (paddr == CSR_ADDR_W'(REG_MODE));
   assign mode_in = mode_wr ? pwdata[0] : mode_ff;
   assign prdata  = {{(CSR_DATA_W-1){1'b0}}, mode_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ENCODE;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign accept = push && !full;

   b64c_front u_front (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .clear     (mode_wr),
      .accept    (accept),
      .data_byte (req_data_byte),
      .last_in   (req_last_in),
      .job       (front_job),
      .job_valid (front_valid)
   );

   b64c_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (front_valid),
      .wr_job (front_job),
      .rd_en  (head_done),
      .rd_job (head_job),
      .full   (full),
      .empty  (q_empty)
   );

   b64c_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_job      (head_job),
      .head_valid    (!q_empty),
      .head_done     (head_done),
      .pop           (pop),
      .empty         (empty),
      .out_byte      (rsp_out_byte),
      .out_last      (rsp_out_last),
      .out_none      (rsp_out_none),
      .stopped_early (rsp_stopped_early)
   );

`ifndef SYNTH
   // An end marker is always the last transaction of its stream
   a_none_is_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_out_none) |-> rsp_out_last)
      else $error("end marker without last flag");

   // Early stop is reported only on the last transaction
   a_early_is_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_stopped_early) |-> rsp_out_last)
      else $error("early stop on a non-final result");

   // An end marker carries a zero byte
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_out_none) |-> (rsp_out_byte == 8'h00))
      else $error("end marker with a non-zero byte");

   // A job only enters the queue for an accepted item
   a_job_from_item: assert property (@(posedge clock) disable iff (reset)
      front_valid |-> accept)
      else $error("job built without an accepted item");
`endif

endmodule

`default_nettype wire
